@@ sv/rmp_pkg.sv @@
// ----------------------------------------------------------------------------
// rmp_pkg: shared types and constants for the region mosaic block
// Register indexes, action and status codes, sequencer states.
// ----------------------------------------------------------------------------
package rmp_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_BLOCK_DEF  = 64;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_BLOCK_SIZE    = 3'd2,
    REG_REGION_X      = 3'd3,
    REG_REGION_Y      = 3'd4,
    REG_REGION_WIDTH  = 3'd5,
    REG_REGION_HEIGHT = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_W    = 2'd1,
    ST_BAD_H    = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_WAIT,
    S_CHECK,
    S_BLK_START,
    S_SUM_RD,
    S_SUM_ACC,
    S_DIV,
    S_WRITE,
    S_BLK_NEXT,
    S_OUT
  } state_t;

endpackage

@@ sv/region_mosaic_pixelate.sv @@
// ----------------------------------------------------------------------------
// region_mosaic_pixelate: RGB frame store with block-average mosaic engine
// Pixel write/read items and a region mosaic run over an on-chip frame.
// ----------------------------------------------------------------------------
// A pixel write goes from the accepting cycle to S_OUT, which writes the
// frame and registers the result; a pixel read passes through S_READ_WAIT
// before S_OUT. The block takes one item at a time, and a finished
// result waits in its own output register so the next item can start. A
// mosaic run does the bounds check in S_CHECK, then walks each block
// twice through the frame memory: S_SUM_RD and S_SUM_ACC per pixel to sum,
// one shared restoring divider stepping one quotient bit per cycle per colour
// channel, S_WRITE per pixel to write back, and S_BLK_START and S_BLK_NEXT
// for block set-up. The frame memory is not cleared; pixels must be written
// before they are read or averaged.
module region_mosaic_pixelate #(
  parameter int MAX_WIDTH  = rmp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rmp_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_BLOCK  = rmp_pkg::MAX_BLOCK_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_pixel_x,
  input  logic [7:0] in_pixel_y,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = XW + YW;
  localparam int CNT_MAX = MAX_BLOCK * MAX_BLOCK;
  localparam int CW = $clog2(CNT_MAX + 1);
  localparam int SW = CW + 8;
  localparam int QW = SW;

  // configuration
  logic [8:0] img_w_r, img_h_r, reg_w_r, reg_h_r;
  logic [6:0] blk_r;
  logic [7:0] reg_x_r, reg_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 9'd256;
      img_h_r <= 9'd256;
      blk_r   <= 7'd10;
      reg_x_r <= 8'd0;
      reg_y_r <= 8'd0;
      reg_w_r <= 9'd256;
      reg_h_r <= 9'd256;
    end else if (cfg_valid) begin
      case (rmp_pkg::reg_idx_t'(cfg_index))
        rmp_pkg::REG_IMAGE_WIDTH:   img_w_r <= cfg_data;
        rmp_pkg::REG_IMAGE_HEIGHT:  img_h_r <= cfg_data;
        rmp_pkg::REG_BLOCK_SIZE:    blk_r   <= cfg_data[6:0];
        rmp_pkg::REG_REGION_X:      reg_x_r <= cfg_data[7:0];
        rmp_pkg::REG_REGION_Y:      reg_y_r <= cfg_data[7:0];
        rmp_pkg::REG_REGION_WIDTH:  reg_w_r <= cfg_data;
        rmp_pkg::REG_REGION_HEIGHT: reg_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes, 13 bits covers every coordinate used here
  logic [12:0] eff_w, eff_h, eff_b;
  always_comb begin
    eff_w = (img_w_r == 9'd0) ? 13'd1 :
            ({4'd0, img_w_r} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, img_w_r};
    eff_h = (img_h_r == 9'd0) ? 13'd1 :
            ({4'd0, img_h_r} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, img_h_r};
    eff_b = (blk_r == 7'd0) ? 13'd1 :
            ({6'd0, blk_r} > 13'(MAX_BLOCK)) ? 13'(MAX_BLOCK) : {6'd0, blk_r};
  end

  // frame memory
  logic [23:0] mem [DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [23:0] mem_wd, mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  // sequencer registers
  rmp_pkg::state_t state_r, state_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [12:0] px_r, px_nxt, py_r, py_nxt;
  logic [23:0] pix_r, pix_nxt;
  logic [12:0] bx_r, bx_nxt, by_r, by_nxt;   // block origin
  logic [12:0] xe_r, xe_nxt, ye_r, ye_nxt;   // clipped block end
  logic [12:0] cx_r, cx_nxt, cy_r, cy_nxt;   // walk position
  logic [12:0] endx_r, endx_nxt, endy_r, endy_nxt;
  logic [SW-1:0] sum_r [3];
  logic [SW-1:0] sum_nxt [3];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [$clog2(QW+1)-1:0] bit_r, bit_nxt;
  logic [SW-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [7:0]  avg_r [3];
  logic [7:0]  avg_nxt [3];
  logic [23:0] wrk_rgb_r, wrk_rgb_nxt;
  logic [1:0]  wrk_st_r, wrk_st_nxt;
  logic [23:0] res_rgb_r, res_rgb_nxt;
  logic [1:0]  res_st_r, res_st_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [SW:0] rem_sh;
  logic [SW-1:0] num_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r <= act_nxt; px_r <= px_nxt; py_r <= py_nxt; pix_r <= pix_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt; xe_r <= xe_nxt; ye_r <= ye_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; endx_r <= endx_nxt; endy_r <= endy_nxt;
    for (int i = 0; i < 3; i++) begin
      sum_r[i] <= sum_nxt[i];
      avg_r[i] <= avg_nxt[i];
    end
    cnt_r <= cnt_nxt; ch_r <= ch_nxt; bit_r <= bit_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt;
    wrk_rgb_r <= wrk_rgb_nxt; wrk_st_r <= wrk_st_nxt;
    res_rgb_r <= res_rgb_nxt; res_st_r <= res_st_nxt;
  end

  assign in_ready      = (state_r == rmp_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_red_out   = res_rgb_r[23:16];
  assign out_green_out = res_rgb_r[15:8];
  assign out_blue_out  = res_rgb_r[7:0];
  assign out_status    = res_st_r;

  function automatic logic [AW-1:0] addr_of(input logic [12:0] x, input logic [12:0] y);
    return AW'(y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(x[XW-1:0]);
  endfunction

  always_comb begin
    state_nxt = state_r; act_nxt = act_r; px_nxt = px_r; py_nxt = py_r;
    pix_nxt = pix_r; bx_nxt = bx_r; by_nxt = by_r; xe_nxt = xe_r; ye_nxt = ye_r;
    cx_nxt = cx_r; cy_nxt = cy_r; endx_nxt = endx_r; endy_nxt = endy_r;
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = sum_r[i];
      avg_nxt[i] = avg_r[i];
    end
    cnt_nxt = cnt_r; ch_nxt = ch_r; bit_nxt = bit_r; rem_nxt = rem_r; quo_nxt = quo_r;
    wrk_rgb_nxt = wrk_rgb_r; wrk_st_nxt = wrk_st_r;
    res_rgb_nxt = res_rgb_r; res_st_nxt = res_st_r; out_valid_nxt = out_valid_r;
    mem_we = 1'b0;
    mem_wa = addr_of(cx_r, cy_r);
    mem_wd = {avg_r[0], avg_r[1], avg_r[2]};
    mem_ra = addr_of(cx_r, cy_r);
    num_cur = sum_r[ch_r];
    rem_sh = {rem_r, num_cur[SW-1]};

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      rmp_pkg::S_IDLE: begin
        if (in_valid) begin
          // start the pixel read at the transfer so the data lands in the wait cycle
          mem_ra  = addr_of({5'd0, in_pixel_x}, {5'd0, in_pixel_y});
          act_nxt = in_action;
          px_nxt  = {5'd0, in_pixel_x};
          py_nxt  = {5'd0, in_pixel_y};
          pix_nxt = {in_red_in, in_green_in, in_blue_in};
          wrk_rgb_nxt = 24'd0;
          wrk_st_nxt  = rmp_pkg::ST_OK;
          endx_nxt = {5'd0, reg_x_r} + {4'd0, reg_w_r};
          endy_nxt = {5'd0, reg_y_r} + {4'd0, reg_h_r};
          unique case (rmp_pkg::action_t'(in_action))
            rmp_pkg::ACT_WRITE: state_nxt = rmp_pkg::S_OUT;
            rmp_pkg::ACT_RUN:   state_nxt = rmp_pkg::S_CHECK;
            rmp_pkg::ACT_READ: begin
              cx_nxt = {5'd0, in_pixel_x};
              cy_nxt = {5'd0, in_pixel_y};
              state_nxt = rmp_pkg::S_READ_WAIT;
            end
            default: state_nxt = rmp_pkg::S_OUT;
          endcase
        end
      end
      rmp_pkg::S_READ_WAIT: begin
        if (px_r < eff_w && py_r < eff_h) wrk_rgb_nxt = mem_rd_r;
        state_nxt = rmp_pkg::S_OUT;
      end
      rmp_pkg::S_CHECK: begin
        if (endx_r > eff_w) begin
          wrk_st_nxt = rmp_pkg::ST_BAD_W; state_nxt = rmp_pkg::S_OUT;
        end else if (endy_r > eff_h) begin
          wrk_st_nxt = rmp_pkg::ST_BAD_H; state_nxt = rmp_pkg::S_OUT;
        end else if (reg_w_r == 9'd0 || reg_h_r == 9'd0) begin
          state_nxt = rmp_pkg::S_OUT;
        end else begin
          bx_nxt = {5'd0, reg_x_r};
          by_nxt = {5'd0, reg_y_r};
          state_nxt = rmp_pkg::S_BLK_START;
        end
      end
      rmp_pkg::S_BLK_START: begin
        xe_nxt = (bx_r + eff_b < eff_w) ? bx_r + eff_b : eff_w;
        ye_nxt = (by_r + eff_b < eff_h) ? by_r + eff_b : eff_h;
        cx_nxt = bx_r; cy_nxt = by_r;
        for (int i = 0; i < 3; i++) sum_nxt[i] = '0;
        cnt_nxt = '0;
        state_nxt = rmp_pkg::S_SUM_RD;
      end
      rmp_pkg::S_SUM_RD: state_nxt = rmp_pkg::S_SUM_ACC;
      rmp_pkg::S_SUM_ACC: begin
        sum_nxt[0] = sum_r[0] + SW'(mem_rd_r[23:16]);
        sum_nxt[1] = sum_r[1] + SW'(mem_rd_r[15:8]);
        sum_nxt[2] = sum_r[2] + SW'(mem_rd_r[7:0]);
        cnt_nxt = cnt_r + 1'b1;
        if (cx_r + 13'd1 < xe_r) begin
          cx_nxt = cx_r + 13'd1; state_nxt = rmp_pkg::S_SUM_RD;
        end else if (cy_r + 13'd1 < ye_r) begin
          cx_nxt = bx_r; cy_nxt = cy_r + 13'd1; state_nxt = rmp_pkg::S_SUM_RD;
        end else begin
          ch_nxt = 2'd0; bit_nxt = '0; rem_nxt = '0; quo_nxt = '0;
          state_nxt = rmp_pkg::S_DIV;
        end
      end
      rmp_pkg::S_DIV: begin
        // restoring divide, one quotient bit per cycle, channel by channel
        sum_nxt[ch_r] = {num_cur[SW-2:0], 1'b0};
        if (rem_sh >= (SW+1)'(cnt_r)) begin
          rem_nxt = SW'(rem_sh - (SW+1)'(cnt_r));
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = SW'(rem_sh);
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
        if (bit_r == $bits(bit_r)'(QW-1)) begin
          avg_nxt[ch_r] = quo_nxt[7:0];
          bit_nxt = '0; rem_nxt = '0; quo_nxt = '0;
          if (ch_r == 2'd2) begin
            cx_nxt = bx_r; cy_nxt = by_r;
            state_nxt = rmp_pkg::S_WRITE;
          end else begin
            ch_nxt = ch_r + 2'd1;
          end
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      rmp_pkg::S_WRITE: begin
        mem_we = 1'b1;
        if (cx_r + 13'd1 < xe_r) begin
          cx_nxt = cx_r + 13'd1;
        end else if (cy_r + 13'd1 < ye_r) begin
          cx_nxt = bx_r; cy_nxt = cy_r + 13'd1;
        end else begin
          state_nxt = rmp_pkg::S_BLK_NEXT;
        end
      end
      rmp_pkg::S_BLK_NEXT: begin
        if (bx_r + eff_b < endx_r) begin
          bx_nxt = bx_r + eff_b; state_nxt = rmp_pkg::S_BLK_START;
        end else if (by_r + eff_b < endy_r) begin
          bx_nxt = {5'd0, reg_x_r}; by_nxt = by_r + eff_b;
          state_nxt = rmp_pkg::S_BLK_START;
        end else begin
          state_nxt = rmp_pkg::S_OUT;
        end
      end
      rmp_pkg::S_OUT: begin
        if (act_r == rmp_pkg::ACT_WRITE && px_r < eff_w && py_r < eff_h) begin
          mem_we = 1'b1;
          mem_wa = addr_of(px_r, py_r);
          mem_wd = pix_r;
        end
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          res_rgb_nxt   = wrk_rgb_r;
          res_st_nxt    = wrk_st_r;
          state_nxt = rmp_pkg::S_IDLE;
        end
        // hold the write until the result slot frees; repeated writes are harmless
      end
      default: state_nxt = rmp_pkg::S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == rmp_pkg::S_IDLE)
    else $error("ready outside idle");
  a_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rmp_pkg::ST_OK |-> out_red_out == 8'd0 &&
      out_green_out == 8'd0 && out_blue_out == 8'd0)
    else $error("colour on failed run");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back to back accept");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rmp_pkg::S_DIV |-> cnt_r != '0)
    else $error("divide by zero count");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_out) &&
      $stable(out_green_out) && $stable(out_blue_out) && $stable(out_status))
    else $error("result changed while waiting");

endmodule

@@ test/tb_region_mosaic_pixelate.sv @@
// ----------------------------------------------------------------------------
// tb_region_mosaic_pixelate: self-checking bench for the region mosaic block
// Drives pixel writes, reads and mosaic runs under random idling and a long
// output stall, predicts every result from a local frame copy and compares.
// ----------------------------------------------------------------------------
module tb_region_mosaic_pixelate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 60000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    rmp_pkg::status_t status;
  } pixel_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = rmp_pkg::ACT_NONE;
  logic [7:0] in_pixel_x = '0;
  logic [7:0] in_pixel_y = '0;
  logic [7:0] in_red_in = '0;
  logic [7:0] in_green_in = '0;
  logic [7:0] in_blue_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic [1:0] out_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = rmp_pkg::REG_IMAGE_WIDTH;
  logic [8:0] cfg_data = '0;

  // local copy of the frame and the register file
  logic [23:0] frame_mem [65536];
  bit          frame_seen [65536];
  int unsigned img_w_reg, img_h_reg, blk_reg, rx_reg, ry_reg, rw_reg, rh_reg;

  pixel_result_t pending_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  int  hold_reqs = 0;
  int  hold_served = 0;
  bit  calm = 1'b0;

  region_mosaic_pixelate dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned img_w();
    return clamp(img_w_reg, 1, 256);
  endfunction
  function automatic int unsigned img_h();
    return clamp(img_h_reg, 1, 256);
  endfunction
  function automatic int unsigned blk();
    return clamp(blk_reg, 1, 64);
  endfunction

  function automatic void average_tile(int unsigned bx, int unsigned by);
    int unsigned xe, ye, sr, sg, sb, cnt;
    logic [23:0] avg;
    xe = (bx + blk() < img_w()) ? bx + blk() : img_w();
    ye = (by + blk() < img_h()) ? by + blk() : img_h();
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int unsigned y = by; y < ye; y++)
      for (int unsigned x = bx; x < xe; x++) begin
        sr += frame_mem[y*256+x][23:16];
        sg += frame_mem[y*256+x][15:8];
        sb += frame_mem[y*256+x][7:0];
        cnt++;
      end
    if (cnt == 0) return;
    avg = {8'(sr / cnt), 8'(sg / cnt), 8'(sb / cnt)};
    for (int unsigned y = by; y < ye; y++)
      for (int unsigned x = bx; x < xe; x++)
        frame_mem[y*256+x] = avg;
  endfunction

  function automatic rmp_pkg::status_t region_status();
    if (rx_reg + rw_reg > img_w()) return rmp_pkg::ST_BAD_W;
    if (ry_reg + rh_reg > img_h()) return rmp_pkg::ST_BAD_H;
    return rmp_pkg::ST_OK;
  endfunction

  function automatic pixel_result_t predict_pixel(rmp_pkg::action_t act, int unsigned x,
                                                  int unsigned y, logic [23:0] rgb);
    pixel_result_t res;
    bit in_image;
    res = '{8'd0, 8'd0, 8'd0, rmp_pkg::ST_OK};
    in_image = (x < img_w()) && (y < img_h());
    case (act)
      rmp_pkg::ACT_WRITE: begin
        if (in_image) frame_mem[y*256+x] = rgb;
      end
      rmp_pkg::ACT_RUN: begin
        res.status = region_status();
        if (res.status == rmp_pkg::ST_OK)
          for (int unsigned ty = ry_reg; ty < ry_reg + rh_reg; ty += blk())
            for (int unsigned tx = rx_reg; tx < rx_reg + rw_reg; tx += blk())
              average_tile(tx, ty);
      end
      rmp_pkg::ACT_READ: begin
        if (in_image) {res.red, res.green, res.blue} = frame_mem[y*256+x];
      end
      default: ;
    endcase
    return res;
  endfunction

  // one item over the input channel; prediction taken at the transfer
  task automatic send_item(rmp_pkg::action_t act, int unsigned x, int unsigned y,
                           logic [23:0] rgb);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_pixel_x  <= 8'(x);
    in_pixel_y  <= 8'(y);
    in_red_in   <= rgb[23:16];
    in_green_in <= rgb[15:8];
    in_blue_in  <= rgb[7:0];
    do @(posedge clk); while (!in_ready);
    if (act == rmp_pkg::ACT_WRITE && x < img_w() && y < img_h())
      frame_seen[y*256+x] = 1'b1;
    pending_q.push_back(predict_pixel(act, x, y, rgb));
  endtask

  task automatic write_pixel(int unsigned x, int unsigned y);
    send_item(rmp_pkg::ACT_WRITE, x, y, 24'($urandom));
  endtask

  // write every pixel the next run will average that was not written yet, then run
  task automatic run_mosaic_item();
    int unsigned xe, ye;
    if (region_status() == rmp_pkg::ST_OK)
      for (int unsigned ty = ry_reg; ty < ry_reg + rh_reg; ty += blk())
        for (int unsigned tx = rx_reg; tx < rx_reg + rw_reg; tx += blk()) begin
          xe = (tx + blk() < img_w()) ? tx + blk() : img_w();
          ye = (ty + blk() < img_h()) ? ty + blk() : img_h();
          for (int unsigned y = ty; y < ye; y++)
            for (int unsigned x = tx; x < xe; x++)
              if (!frame_seen[y*256+x]) write_pixel(x, y);
        end
    send_item(rmp_pkg::ACT_RUN, $urandom_range(255), $urandom_range(255), 24'($urandom));
  endtask

  task automatic read_pixel(int unsigned x, int unsigned y);
    if (x < img_w() && y < img_h() && !frame_seen[y*256+x]) write_pixel(x, y);
    send_item(rmp_pkg::ACT_READ, x, y, 24'($urandom));
  endtask

  task automatic cfg_write(rmp_pkg::reg_idx_t idx, logic [8:0] val);
    // drop the input before the block goes idle again
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rmp_pkg::REG_IMAGE_WIDTH:   img_w_reg = val;
      rmp_pkg::REG_IMAGE_HEIGHT:  img_h_reg = val;
      rmp_pkg::REG_BLOCK_SIZE:    blk_reg = val[6:0];
      rmp_pkg::REG_REGION_X:      rx_reg = val[7:0];
      rmp_pkg::REG_REGION_Y:      ry_reg = val[7:0];
      rmp_pkg::REG_REGION_WIDTH:  rw_reg = val;
      rmp_pkg::REG_REGION_HEIGHT: rh_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_region(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
    cfg_write(rmp_pkg::REG_REGION_X, 9'(x));
    cfg_write(rmp_pkg::REG_REGION_Y, 9'(y));
    cfg_write(rmp_pkg::REG_REGION_WIDTH, 9'(w));
    cfg_write(rmp_pkg::REG_REGION_HEIGHT, 9'(h));
  endtask

  // reset image: corner pixels, extreme colours, bounds failures
  task automatic test_reset_image();
    send_item(rmp_pkg::ACT_WRITE, 0, 0, 24'h000000);
    send_item(rmp_pkg::ACT_WRITE, 255, 255, 24'hFFFFFF);
    send_item(rmp_pkg::ACT_WRITE, 255, 0, 24'hFF00FF);
    read_pixel(0, 0);
    read_pixel(255, 255);
    read_pixel(255, 0);
    send_item(rmp_pkg::ACT_NONE, 255, 255, 24'hFFFFFF);
    cfg_write(rmp_pkg::REG_REGION_X, 9'd255);
    run_mosaic_item();
    set_region(0, 1, 256, 256);
    run_mosaic_item();
    set_region(255, 255, 0, 0);
    run_mosaic_item();
    read_pixel(255, 255);
  endtask

  // block larger than the region, clipped at the far image corner
  task automatic test_edge_block();
    cfg_write(rmp_pkg::REG_BLOCK_SIZE, 9'd127);
    set_region(250, 251, 3, 2);
    run_mosaic_item();
    read_pixel(255, 255);
    read_pixel(250, 251);
  endtask

  // out-of-range register values and pixels outside the image
  task automatic test_clamping();
    cfg_write(rmp_pkg::REG_IMAGE_WIDTH, 9'd0);
    cfg_write(rmp_pkg::REG_IMAGE_HEIGHT, 9'd511);
    cfg_write(rmp_pkg::REG_BLOCK_SIZE, 9'd0);
    set_region(0, 0, 1, 2);
    send_item(rmp_pkg::ACT_WRITE, 1, 3, 24'h123456);
    read_pixel(1, 3);
    run_mosaic_item();
    read_pixel(0, 1);
    set_region(0, 0, 2, 1);
    run_mosaic_item();
  endtask

  task automatic test_full_image();
    cfg_write(rmp_pkg::REG_IMAGE_WIDTH, 9'd12);
    cfg_write(rmp_pkg::REG_IMAGE_HEIGHT, 9'd10);
    cfg_write(rmp_pkg::REG_BLOCK_SIZE, 9'd5);
    set_region(0, 0, 12, 10);
    run_mosaic_item();
    read_pixel(11, 9);
    read_pixel(10, 0);
    read_pixel(12, 3);
  endtask

  task automatic random_setting();
    int unsigned w, h, x, y;
    w = $urandom_range(4, 24);
    h = $urandom_range(4, 24);
    cfg_write(rmp_pkg::REG_IMAGE_WIDTH, 9'(w));
    cfg_write(rmp_pkg::REG_IMAGE_HEIGHT, 9'(h));
    cfg_write(rmp_pkg::REG_BLOCK_SIZE, ($urandom_range(9) == 0) ? 9'($urandom_range(127))
                                                                : 9'($urandom_range(1, 8)));
    if ($urandom_range(4) == 0) begin
      set_region($urandom_range(255), $urandom_range(255),
                 $urandom_range(256), $urandom_range(256));
    end else begin
      x = $urandom_range(w - 1);
      y = $urandom_range(h - 1);
      set_region(x, y, $urandom_range(w - x), $urandom_range(h - y));
    end
  endtask

  task automatic random_items(int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(3) == 0) write_pixel($urandom_range(255), $urandom_range(255));
        else write_pixel($urandom_range(img_w() - 1), $urandom_range(img_h() - 1));
      end else if (pick < 80) begin
        if ($urandom_range(3) == 0) read_pixel($urandom_range(255), $urandom_range(255));
        else read_pixel($urandom_range(img_w() - 1), $urandom_range(img_h() - 1));
      end else if (pick < 95) begin
        run_mosaic_item();
      end else begin
        send_item(rmp_pkg::ACT_NONE, $urandom_range(255), $urandom_range(255),
                  24'($urandom));
      end
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 10; i++) begin
      calm = (i == 4);
      random_setting();
      random_items(60);
    end
    calm = 1'b0;
  endtask

  // stall the output and keep offering items so the block blocks its input
  task automatic test_output_hold();
    hold_reqs++;
    random_items(30);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: rgb %h%h%h status %0d",
                                       out_red_out, out_green_out, out_blue_out, out_status);
      end else begin
        want = pending_q.pop_front();
        if (out_red_out !== want.red || out_green_out !== want.green ||
            out_blue_out !== want.blue || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rgb %h%h%h status %0d, got rgb %h%h%h status %0d",
                     want.red, want.green, want.blue, want.status,
                     out_red_out, out_green_out, out_blue_out, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    img_w_reg = 256; img_h_reg = 256; blk_reg = 10;
    rx_reg = 0; ry_reg = 0; rw_reg = 256; rh_reg = 256;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_image();
    test_edge_block();
    test_clamping();
    test_full_image();
    test_random();
    test_output_hold();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ region_mosaic_pixelate.f @@
sv/rmp_pkg.sv
sv/region_mosaic_pixelate.sv
test/tb_region_mosaic_pixelate.sv
